@@ sv/ohmar_pkg.sv @@
// Shared types and codes for the ohmmeter auto-range controller.
package ohmar_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_SAFE_HIGH   = 3'd0;
    localparam logic [2:0] REG_SAFE_LOW    = 3'd1;
    localparam logic [2:0] REG_TARGET      = 3'd2;
    localparam logic [2:0] REG_ADC_HIGH    = 3'd3;
    localparam logic [2:0] REG_ADC_LOW     = 3'd4;
    localparam logic [2:0] REG_CUR_OFFSET  = 3'd5;
    localparam logic [2:0] REG_TRANS_HIGH  = 3'd6;
    localparam logic [2:0] REG_TRANS_MID   = 3'd7;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TRIP    = 2'd1;
    localparam logic [1:0] STATUS_NO_CURR = 2'd2;

    // Relay range codes.
    localparam logic [1:0] MODE_PROTECTED = 2'd0;
    localparam logic [1:0] MODE_HIGH      = 2'd1;
    localparam logic [1:0] MODE_MID       = 2'd2;

    typedef struct packed {
        logic signed [18:0] probe_voltage;
        logic        [15:0] shunt_adc_voltage;
    } sample_t;

    typedef struct packed {
        logic [31:0] resistance_ohms;
        logic [1:0]  status;
        logic [6:0]  dac_step;
        logic [1:0]  relay_mode;
    } result_t;

endpackage

@@ sv/ohmmeter_autorange_controller_top.sv @@
// Auto-ranging ohmmeter controller: range and drive control plus resistance divider.
// Sequencing: an item that needs no division (protection trip, no usable current, or a
// non-positive probe voltage) goes from acceptance straight to the finish state; otherwise
// it passes a multiply step, a saturation check and the restoring subtract/compare unit,
// one quotient bit per step. The input is stalled while an item is in flight, but a
// waiting result does not stall the next item once the sequencer has handed it over.
// Reset (rst_n, asynchronous, active low) returns the relay to protected mode, the drive
// to zero and all configuration registers to their default values.
module ohmmeter_autorange_controller_top #(
    parameter int DAC_STEPS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  ohmar_pkg::sample_t  sample,
    output logic                result_valid,
    input  logic                result_stall,
    output ohmar_pkg::result_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    // Drive level holds 0..DAC_STEPS; the working copy has room for one step either side
    // and a sign.
    localparam int DW = $clog2(DAC_STEPS + 1);
    localparam int SW = DW + 2;
    localparam logic signed [SW-1:0] D_ONE  = SW'(1);
    localparam logic signed [SW-1:0] D_TWO  = SW'(2);
    localparam logic signed [SW-1:0] D_MAX  = SW'(DAC_STEPS);
    localparam logic signed [SW-1:0] D_TOP  = SW'(DAC_STEPS - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_CHK    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    // Configuration registers.
    logic signed [18:0] safe_high_reg;
    logic signed [18:0] safe_low_reg;
    logic        [17:0] target_reg;
    logic        [15:0] adc_high_reg;
    logic        [15:0] adc_low_reg;
    logic signed [13:0] cur_offset_reg;
    logic        [31:0] trans_high_reg;
    logic        [31:0] trans_mid_reg;

    // Control state.
    logic [1:0]    range_mode_reg, range_mode_next;
    logic [DW-1:0] drive_reg, drive_next;
    logic [2:0]    state_reg, state_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          result_valid_reg, result_valid_next;

    // Working payload.
    logic [17:0]   volt_reg, volt_next;
    logic [31:0]   trans_reg, trans_next;
    logic [16:0]   sc_reg, sc_next;
    logic [50:0]   num_reg, num_next;
    logic [24:0]   rem_reg, rem_next;
    logic [31:0]   quo_reg, quo_next;
    logic [1:0]    status_reg, status_next;
    logic [6:0]    dac_reg, dac_next;
    logic [1:0]    mode_out_reg, mode_out_next;
    ohmar_pkg::result_t result_reg, result_next;

    logic accept;

    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Configuration writes: user must write only while idle; block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_high_reg  <= 19'sd33000;
            safe_low_reg   <= -19'sd1000;
            target_reg     <= 18'd17000;
            adc_high_reg   <= 16'd30000;
            adc_low_reg    <= 16'd1000;
            cur_offset_reg <= -14'sd815;
            trans_high_reg <= 32'd21104640;
            trans_mid_reg  <= 32'd35226;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ohmar_pkg::REG_SAFE_HIGH:  safe_high_reg  <= cfg_data[18:0];
                ohmar_pkg::REG_SAFE_LOW:   safe_low_reg   <= cfg_data[18:0];
                ohmar_pkg::REG_TARGET:     target_reg     <= cfg_data[17:0];
                ohmar_pkg::REG_ADC_HIGH:   adc_high_reg   <= cfg_data[15:0];
                ohmar_pkg::REG_ADC_LOW:    adc_low_reg    <= cfg_data[15:0];
                ohmar_pkg::REG_CUR_OFFSET: cur_offset_reg <= cfg_data[13:0];
                ohmar_pkg::REG_TRANS_HIGH: trans_high_reg <= cfg_data;
                ohmar_pkg::REG_TRANS_MID:  trans_mid_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        logic signed [19:0]   v_ext;
        logic signed [17:0]   sc;
        logic                 unsafe;
        logic                 too_high;
        logic                 too_low;
        logic                 below_target;
        logic [1:0]           mode;
        logic signed [SW-1:0] d;
        logic [DW+6:0]        d_wide;
        logic [49:0]          prod;
        logic [25:0]          rem_shift;
        logic                 ge;

        state_next        = state_reg;
        range_mode_next   = range_mode_reg;
        drive_next        = drive_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg;
        volt_next         = volt_reg;
        trans_next        = trans_reg;
        sc_next           = sc_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        status_next       = status_reg;
        dac_next          = dac_reg;
        mode_out_next     = mode_out_reg;
        result_next       = result_reg;

        // Decision logic on the incoming item.
        v_ext        = 20'(sample.probe_voltage);
        sc           = $signed({2'b00, sample.shunt_adc_voltage}) + 18'(cur_offset_reg);
        unsafe       = (sample.probe_voltage > safe_high_reg)
                    || (sample.probe_voltage < safe_low_reg);
        too_high     = (sample.shunt_adc_voltage >= adc_high_reg);
        too_low      = (sc <= $signed({2'b00, adc_low_reg}));
        below_target = (v_ext < $signed({2'b00, target_reg}));

        mode = (range_mode_reg == ohmar_pkg::MODE_PROTECTED) ? ohmar_pkg::MODE_HIGH
                                                             : range_mode_reg;
        d = $signed({2'b00, drive_reg});
        if (too_high)
        begin
            d = d - D_ONE;
            if (d <= D_ONE)
            begin
                mode = mode + 2'd1;
                d    = D_TOP;
            end
        end
        else if (too_low)
        begin
            d = d + D_ONE;
            if ((d >= D_MAX) && (mode > ohmar_pkg::MODE_HIGH))
            begin
                mode = mode - 2'd1;
                d    = D_TWO;
            end
        end
        else if (below_target)
        begin
            d = d + D_ONE;
        end
        if (d < D_ONE)
        begin
            d = D_ONE;
        end
        else if (d >= D_MAX)
        begin
            d = D_MAX;
        end
        if (mode > ohmar_pkg::MODE_MID)
        begin
            mode = ohmar_pkg::MODE_MID;
        end

        d_wide    = {7'b0, d[DW-1:0]};
        prod      = volt_reg * trans_reg;
        rem_shift = {rem_reg, quo_reg[31]};
        ge        = (rem_shift >= {1'b0, sc_reg, 8'b0});

        // The output register empties whenever the consumer takes the item.
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    quo_next  = '0;
                    volt_next = sample.probe_voltage[17:0];
                    sc_next   = sc[16:0];
                    trans_next = (range_mode_reg == ohmar_pkg::MODE_HIGH) ? trans_high_reg
                                                                          : trans_mid_reg;
                    state_next = ST_FINISH;
                    if (unsafe)
                    begin
                        range_mode_next = ohmar_pkg::MODE_PROTECTED;
                        status_next     = ohmar_pkg::STATUS_TRIP;
                        d_wide          = {7'b0, drive_reg};
                        dac_next        = d_wide[6:0];
                        mode_out_next   = ohmar_pkg::MODE_PROTECTED;
                    end
                    else
                    begin
                        range_mode_next = mode;
                        drive_next      = d[DW-1:0];
                        dac_next        = d_wide[6:0];
                        mode_out_next   = mode;
                        if ((range_mode_reg != ohmar_pkg::MODE_HIGH)
                            && (range_mode_reg != ohmar_pkg::MODE_MID))
                        begin
                            status_next = ohmar_pkg::STATUS_NO_CURR;
                        end
                        else if (sc <= 18'sd0)
                        begin
                            status_next = ohmar_pkg::STATUS_NO_CURR;
                        end
                        else
                        begin
                            status_next = ohmar_pkg::STATUS_OK;
                            if (sample.probe_voltage > 19'sd0)
                            begin
                                state_next = ST_MUL;
                            end
                        end
                    end
                end
            end
            ST_MUL:
            begin
                // Numerator with half the divisor added for round-half-up.
                num_next   = {1'b0, prod} + 51'({sc_reg, 7'b0});
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if ({6'b0, num_reg[50:32]} >= {sc_reg, 8'b0})
                begin
                    quo_next   = '1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rem_next   = {6'b0, num_reg[50:32]};
                    quo_next   = num_reg[31:0];
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? 25'(rem_shift - {1'b0, sc_reg, 8'b0}) : rem_shift[24:0];
                quo_next = {quo_reg[30:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.resistance_ohms = quo_reg;
                    result_next.status          = status_reg;
                    result_next.dac_step        = dac_reg;
                    result_next.relay_mode      = mode_out_reg;
                    result_valid_next           = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            range_mode_reg   <= ohmar_pkg::MODE_PROTECTED;
            drive_reg        <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            range_mode_reg   <= range_mode_next;
            drive_reg        <= drive_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        volt_reg     <= volt_next;
        trans_reg    <= trans_next;
        sc_reg       <= sc_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        status_reg   <= status_next;
        dac_reg      <= dac_next;
        mode_out_reg <= mode_out_next;
        result_reg   <= result_next;
    end

    // A tripped or currentless result never reports a resistance.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ohmar_pkg::STATUS_OK)
        |-> (result.resistance_ohms == 32'd0))
        else $error("nonzero resistance with error status");

    // Protected relay mode is only ever reported alongside a trip.
    a_protected_is_trip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.relay_mode == ohmar_pkg::MODE_PROTECTED)
        |-> (result.status == ohmar_pkg::STATUS_TRIP))
        else $error("protected mode without trip status");

    // An unsafe probe voltage drops the relay to protected mode on the next cycle.
    a_trip_protects: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((sample.probe_voltage > safe_high_reg)
                   || (sample.probe_voltage < safe_low_reg))
        |=> (range_mode_reg == ohmar_pkg::MODE_PROTECTED))
        else $error("trip did not force protected mode");

    // The drive level stays within its range and the relay never takes the unused code.
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, drive_reg} <= (DW + 1)'(DAC_STEPS)) && (range_mode_reg != 2'd3))
        else $error("drive or range out of bounds");

endmodule
